FILE: rtl/ict_pkg.sv
package ict_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_WHOLE = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [1:0] STAT_OUTSIDE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_LD_FILL, ST_FILL, ST_LD_LEFT, ST_LEFT,
        ST_LD_RIGHT, ST_RIGHT, ST_LD_INC, ST_INC_RD, ST_INC_WR,
        ST_LD_QRY, ST_QRY, ST_DRAIN, ST_DONE
    } state_t;

    typedef enum logic [1:0] {ACT_NONE, ACT_FIRST, ACT_GROW, ACT_QUERY} act_t;
    typedef enum logic [2:0] {SEG_FILL, SEG_LEFT, SEG_RIGHT, SEG_INC, SEG_QRY} seg_t;
    typedef enum logic [1:0] {WR_ZERO, WR_ONE, WR_INC} wsel_t;

    typedef struct packed {
        logic  in_load;
        logic  decide;
        logic  seg_load;
        seg_t  seg;
        logic  step;
        logic  rd_en;
        logic  wr_en;
        wsel_t wsel;
        logic  stat_clear;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic run_done;
        logic pipe_busy;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] depth_min;
        logic [15:0] depth_max;
        logic [27:0] depth_sum;
        logic [43:0] depth_sum_squares;
        logic [12:0] range_length;
        logic [31:0] window_first;
        logic [31:0] window_last;
    } res_t;

endpackage

FILE: rtl/ict_ctrl.sv
module ict_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ict_pkg::sts_t   sts,
    output ict_pkg::cmd_t   cmd
);

    ict_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ict_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ict_pkg::ST_IDLE:     if (in_valid) state_next = ict_pkg::ST_DECIDE;
            ict_pkg::ST_DECIDE: begin
                unique case (sts.act)
                    ict_pkg::ACT_FIRST: state_next = ict_pkg::ST_LD_FILL;
                    ict_pkg::ACT_GROW:  state_next = ict_pkg::ST_LD_LEFT;
                    ict_pkg::ACT_QUERY: state_next = ict_pkg::ST_LD_QRY;
                    default:            state_next = ict_pkg::ST_DONE;
                endcase
            end
            ict_pkg::ST_LD_FILL:  state_next = ict_pkg::ST_FILL;
            ict_pkg::ST_FILL:     if (sts.run_done) state_next = ict_pkg::ST_DONE;
            ict_pkg::ST_LD_LEFT:  state_next = ict_pkg::ST_LEFT;
            ict_pkg::ST_LEFT:     if (sts.run_done) state_next = ict_pkg::ST_LD_RIGHT;
            ict_pkg::ST_LD_RIGHT: state_next = ict_pkg::ST_RIGHT;
            ict_pkg::ST_RIGHT:    if (sts.run_done) state_next = ict_pkg::ST_LD_INC;
            ict_pkg::ST_LD_INC:   state_next = ict_pkg::ST_INC_RD;
            ict_pkg::ST_INC_RD:   state_next = sts.run_done ? ict_pkg::ST_DONE
                                                            : ict_pkg::ST_INC_WR;
            ict_pkg::ST_INC_WR:   state_next = ict_pkg::ST_INC_RD;
            ict_pkg::ST_LD_QRY:   state_next = ict_pkg::ST_QRY;
            ict_pkg::ST_QRY:      if (sts.run_done) state_next = ict_pkg::ST_DRAIN;
            ict_pkg::ST_DRAIN:    if (!sts.pipe_busy) state_next = ict_pkg::ST_DONE;
            ict_pkg::ST_DONE:     if (sts.out_free) state_next = ict_pkg::ST_IDLE;
            default:              state_next = ict_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.seg = ict_pkg::SEG_FILL;
        cmd.wsel = ict_pkg::WR_ZERO;
        in_ready = 1'b0;
        unique case (state_reg)
            ict_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.in_load = in_valid;
            end
            ict_pkg::ST_DECIDE:   cmd.decide = 1'b1;
            ict_pkg::ST_LD_FILL: begin
                cmd.seg_load = 1'b1;
                cmd.seg = ict_pkg::SEG_FILL;
            end
            ict_pkg::ST_LD_LEFT: begin
                cmd.seg_load = 1'b1;
                cmd.seg = ict_pkg::SEG_LEFT;
            end
            ict_pkg::ST_LD_RIGHT: begin
                cmd.seg_load = 1'b1;
                cmd.seg = ict_pkg::SEG_RIGHT;
            end
            ict_pkg::ST_LD_INC: begin
                cmd.seg_load = 1'b1;
                cmd.seg = ict_pkg::SEG_INC;
            end
            ict_pkg::ST_LD_QRY: begin
                cmd.seg_load = 1'b1;
                cmd.seg = ict_pkg::SEG_QRY;
                cmd.stat_clear = 1'b1;
            end
            ict_pkg::ST_FILL: begin
                cmd.wr_en = !sts.run_done;
                cmd.step = !sts.run_done;
                cmd.wsel = ict_pkg::WR_ONE;
            end
            ict_pkg::ST_LEFT, ict_pkg::ST_RIGHT: begin
                cmd.wr_en = !sts.run_done;
                cmd.step = !sts.run_done;
                cmd.wsel = ict_pkg::WR_ZERO;
            end
            ict_pkg::ST_INC_RD:   cmd.rd_en = !sts.run_done;
            ict_pkg::ST_INC_WR: begin
                cmd.wr_en = 1'b1;
                cmd.step = 1'b1;
                cmd.wsel = ict_pkg::WR_INC;
            end
            ict_pkg::ST_QRY: begin
                cmd.rd_en = !sts.run_done;
                cmd.step = !sts.run_done;
            end
            ict_pkg::ST_DRAIN: ;
            ict_pkg::ST_DONE:     cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/ict_dp.sv
module ict_dp #(
    parameter int WINDOW_SIZE = ict_pkg::WINDOW_SIZE_DEF,
    parameter int COUNT_BITS  = ict_pkg::COUNT_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    in_op,
    input  logic [15:0]   in_contig,
    input  logic [31:0]   in_begin,
    input  logic [31:0]   in_end,
    input  ict_pkg::cmd_t cmd,
    output ict_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output ict_pkg::res_t res
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int LW = $clog2(WINDOW_SIZE + 1);
    localparam int SW = 2 * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [LW-1:0] x);
        logic [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(x);
        if (s >= (AW+1)'(WINDOW_SIZE)) s = s - (AW+1)'(WINDOW_SIZE);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [LW-1:0] x);
        logic [AW:0] s;
        s = (AW+1)'(a) + (AW+1)'(WINDOW_SIZE) - (AW+1)'(x);
        if (s >= (AW+1)'(WINDOW_SIZE)) s = s - (AW+1)'(WINDOW_SIZE);
        return s[AW-1:0];
    endfunction

    // captured transaction
    logic [1:0]  op_reg;
    logic [15:0] cid_reg;
    logic [31:0] b_reg, e_reg;

    // tracker state
    logic          has_reg;
    logic [AW-1:0] origin_reg;
    logic [31:0]   ws_reg, we_reg;
    logic [15:0]   wc_reg;

    // plan for the current item
    logic [LW-1:0] left_reg, right_reg, len_reg, off_reg;
    logic [AW-1:0] rstart_reg;
    logic [1:0]    status_reg;
    logic          stats_en_reg;

    // walk
    logic [AW-1:0] ptr_reg;
    logic [LW-1:0] cnt_reg;

    logic [COUNT_BITS-1:0] mem [WINDOW_SIZE];
    logic [COUNT_BITS-1:0] rdata_reg, wdata;

    // statistics pipeline
    logic                  rd_vld_reg, vld2_reg, first_reg;
    logic [COUNT_BITS-1:0] d_reg, mn_reg, mx_reg;
    logic [SW-1:0]         sq_reg;
    logic [27:0]           sum_reg;
    logic [43:0]           sqs_reg;

    logic          out_valid_reg;
    ict_pkg::res_t res_reg;

    // decision
    logic          nonempty;
    logic [31:0]   len32, ns, ne;
    logic [32:0]   span;
    ict_pkg::act_t act;
    logic [1:0]    st_code;
    logic          st_stats;
    logic [LW-1:0] p_off, p_len;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg  <= in_op;
            cid_reg <= in_contig;
            b_reg   <= in_begin;
            e_reg   <= in_end;
        end
    end

    assign nonempty = e_reg > b_reg;
    assign len32 = e_reg - b_reg;
    assign ns = (b_reg < ws_reg) ? b_reg : ws_reg;
    assign ne = (e_reg > we_reg) ? e_reg : we_reg;
    assign span = {1'b0, ne} - {1'b0, ns};

    always_comb begin
        act = ict_pkg::ACT_NONE;
        st_code = ict_pkg::STAT_OK;
        st_stats = 1'b0;
        p_off = '0;
        p_len = LW'(len32);
        unique case (op_reg)
            ict_pkg::OP_ADD: begin
                if (!nonempty) begin
                    act = ict_pkg::ACT_NONE;
                end else if (!has_reg) begin
                    if (len32 > 32'(WINDOW_SIZE)) st_code = ict_pkg::STAT_OVERFLOW;
                    else act = ict_pkg::ACT_FIRST;
                end else if (cid_reg != wc_reg) begin
                    st_code = ict_pkg::STAT_MISMATCH;
                end else if (span > 33'(WINDOW_SIZE)) begin
                    st_code = ict_pkg::STAT_OVERFLOW;
                end else begin
                    act = ict_pkg::ACT_GROW;
                    p_off = LW'(b_reg - ns);
                end
            end
            ict_pkg::OP_QUERY: begin
                if (nonempty) begin
                    if (!has_reg || b_reg < ws_reg || e_reg > we_reg) begin
                        st_code = (has_reg && cid_reg != wc_reg) ? ict_pkg::STAT_MISMATCH
                                                                 : ict_pkg::STAT_OUTSIDE;
                    end else if (cid_reg != wc_reg) begin
                        st_code = ict_pkg::STAT_MISMATCH;
                    end else begin
                        act = ict_pkg::ACT_QUERY;
                        st_stats = 1'b1;
                        p_off = LW'(b_reg - ws_reg);
                    end
                end
            end
            ict_pkg::OP_CLEAR: act = ict_pkg::ACT_NONE;
            default: begin
                if (has_reg) begin
                    act = ict_pkg::ACT_QUERY;
                    st_stats = 1'b1;
                    p_len = LW'(we_reg - ws_reg);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_reg    <= 1'b0;
            origin_reg <= '0;
            ws_reg     <= '0;
            we_reg     <= '0;
            wc_reg     <= '0;
        end else if (cmd.decide) begin
            if (op_reg == ict_pkg::OP_CLEAR) begin
                has_reg    <= 1'b0;
                origin_reg <= '0;
                ws_reg     <= '0;
                we_reg     <= '0;
                wc_reg     <= '0;
            end else if (act == ict_pkg::ACT_FIRST) begin
                has_reg    <= 1'b1;
                origin_reg <= '0;
                ws_reg     <= b_reg;
                we_reg     <= e_reg;
                wc_reg     <= cid_reg;
            end else if (act == ict_pkg::ACT_GROW) begin
                origin_reg <= wrap_sub(origin_reg, LW'(ws_reg - ns));
                ws_reg     <= ns;
                we_reg     <= ne;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            left_reg     <= LW'(ws_reg - ns);
            right_reg    <= LW'(ne - we_reg);
            rstart_reg   <= wrap_add(origin_reg, LW'(we_reg - ws_reg));
            len_reg      <= p_len;
            off_reg      <= p_off;
            status_reg   <= st_code;
            stats_en_reg <= st_stats;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.seg_load) begin
            case (cmd.seg)
                ict_pkg::SEG_LEFT:  cnt_reg <= left_reg;
                ict_pkg::SEG_RIGHT: cnt_reg <= right_reg;
                default:            cnt_reg <= len_reg;
            endcase
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seg_load) begin
            case (cmd.seg)
                ict_pkg::SEG_FILL:  ptr_reg <= '0;
                ict_pkg::SEG_LEFT:  ptr_reg <= origin_reg;
                ict_pkg::SEG_RIGHT: ptr_reg <= rstart_reg;
                default:            ptr_reg <= wrap_add(origin_reg, off_reg);
            endcase
        end else if (cmd.step) begin
            ptr_reg <= (ptr_reg == AW'(WINDOW_SIZE - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_comb begin
        case (cmd.wsel)
            ict_pkg::WR_ONE: wdata = COUNT_BITS'(1);
            ict_pkg::WR_INC: wdata = (rdata_reg == CMAX) ? rdata_reg : rdata_reg + 1'b1;
            default:         wdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[ptr_reg] <= wdata;
        if (cmd.rd_en) rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            vld2_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en && cmd.step;
            vld2_reg   <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            d_reg  <= rdata_reg;
            sq_reg <= SW'(rdata_reg) * SW'(rdata_reg);
        end
        if (cmd.stat_clear) begin
            first_reg <= 1'b1;
            mn_reg    <= '0;
            mx_reg    <= '0;
            sum_reg   <= '0;
            sqs_reg   <= '0;
        end else if (vld2_reg) begin
            first_reg <= 1'b0;
            if (first_reg || d_reg < mn_reg) mn_reg <= d_reg;
            if (first_reg || d_reg > mx_reg) mx_reg <= d_reg;
            sum_reg <= sum_reg + 28'(d_reg);
            sqs_reg <= sqs_reg + 44'(sq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            res_reg.status            <= status_reg;
            res_reg.window_first      <= ws_reg;
            res_reg.window_last       <= we_reg;
            res_reg.depth_min         <= stats_en_reg ? 16'(mn_reg) : 16'd0;
            res_reg.depth_max         <= stats_en_reg ? 16'(mx_reg) : 16'd0;
            res_reg.depth_sum         <= stats_en_reg ? sum_reg : 28'd0;
            res_reg.depth_sum_squares <= stats_en_reg ? sqs_reg : 44'd0;
            res_reg.range_length      <= stats_en_reg ? 13'(len_reg) : 13'd0;
        end
    end

    assign sts.act       = act;
    assign sts.run_done  = (cnt_reg == '0);
    assign sts.pipe_busy = rd_vld_reg | vld2_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign res           = res_reg;

endmodule

FILE: rtl/interval_coverage_tracker.sv
// After the decision, clear, empty and rejected items go straight to the result register;
// a first add fills the N interval positions; a later add zeroes the L, R new positions on
// each side, then increments the N positions, each a read then a write on the depth memory.
// A query makes one memory read per position, followed by a two-stage statistics pipe.
// One item at a time: the next transaction is taken in the cycle after the result is loaded,
// even while it waits. Reset (aresetn low, synchronous) empties the window, not the memory.
module interval_coverage_tracker #(
    parameter int WINDOW_SIZE = ict_pkg::WINDOW_SIZE_DEF,
    parameter int COUNT_BITS  = ict_pkg::COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // contig_id, region_begin, region_end
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    // depth_min, depth_max, depth_sum, depth_sum_squares, range_length,
    // window_first, window_last, zero pad
    output logic [183:0] m_tdata,
    output logic [1:0]   m_tuser    // status
);

    ict_pkg::cmd_t cmd;
    ict_pkg::sts_t sts;
    ict_pkg::res_t res;

    ict_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ict_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (s_tuser),
        .in_contig (s_tdata[15:0]),
        .in_begin  (s_tdata[47:16]),
        .in_end    (s_tdata[79:48]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .res       (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {3'b000, res.window_last, res.window_first, res.range_length,
                      res.depth_sum_squares, res.depth_sum, res.depth_max, res.depth_min};

endmodule

FILE: rtl/ict_chk.sv
module ict_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [79:0]  s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [183:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // one item in flight: no second transaction right after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // statistics fields (bits 116:0) are zero on any error status
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ict_pkg::STAT_OK |-> m_tdata[116:0] == '0)
        else $error("statistics on error result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // window end never below window start
    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[180:149] >= m_tdata[148:117])
        else $error("window inverted");

endmodule

bind interval_coverage_tracker ict_chk u_chk (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] contig;
        logic [31:0] rbeg;
        logic [31:0] rend;
    } cmd_item_t;

    localparam int STORE_SIZE   = 4096;
    localparam int STALL_LIMIT  = 200000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;   // contig_id, region_begin, region_end
    logic [1:0]   s_tuser = '0;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // depth_min, depth_max, depth_sum, depth_sum_squares, range_length,
    // window_first, window_last, zero pad
    logic [183:0] m_tdata;
    logic [1:0]   m_tuser;        // status

    interval_coverage_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // pileup model state
    logic [15:0] cov_depth [STORE_SIZE];
    logic [11:0] cov_origin = '0;
    logic [31:0] win_start = '0;
    logic [31:0] win_stop = '0;
    logic [15:0] win_contig = '0;
    bit          win_valid = 0;

    cmd_item_t       cmd_q[$];
    ict_pkg::res_t   pileup_q[$];
    int        sent_cnt = 0;
    int        taken_cnt = 0;
    int        mismatch_cnt = 0;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;

    // generator-side anchor for well-formed sequences
    logic [15:0] gen_contig;
    logic [31:0] gen_anchor;

    function automatic logic [11:0] slot_of(logic [31:0] offset);
        return cov_origin + offset[11:0];
    endfunction

    function automatic void range_stats(logic [31:0] first, logic [31:0] len,
                                        ref ict_pkg::res_t r);
        logic [15:0] d;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [63:0] sum;
        logic [63:0] sq;
        mn = 0; mx = 0; sum = 0; sq = 0;
        for (int unsigned i = 0; i < len; i++) begin
            d = cov_depth[slot_of(first + i)];
            if (i == 0 || d < mn) mn = d;
            if (i == 0 || d > mx) mx = d;
            sum += d;
            sq += 64'(d) * 64'(d);
        end
        r.depth_min = mn;
        r.depth_max = mx;
        r.depth_sum = sum[27:0];
        r.depth_sum_squares = sq[43:0];
        r.range_length = len[12:0];
    endfunction

    function automatic logic [1:0] add_interval(logic [15:0] contig, logic [31:0] b,
                                                logic [31:0] e);
        logic [31:0] len;
        logic [31:0] ns;
        logic [31:0] ne;
        logic [31:0] old_len;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] off;
        logic [11:0] k;
        if (e <= b) return ict_pkg::STAT_OK;
        len = e - b;
        if (!win_valid) begin
            if (len > STORE_SIZE) return ict_pkg::STAT_OVERFLOW;
            cov_origin = 0;
            win_start = b;
            win_stop = e;
            win_contig = contig;
            win_valid = 1;
            for (int unsigned i = 0; i < len; i++) cov_depth[i] = 16'd1;
            return ict_pkg::STAT_OK;
        end
        if (contig != win_contig) return ict_pkg::STAT_MISMATCH;
        ns = (b < win_start) ? b : win_start;
        ne = (e > win_stop) ? e : win_stop;
        if (ne - ns > STORE_SIZE) return ict_pkg::STAT_OVERFLOW;
        old_len = win_stop - win_start;
        left = win_start - ns;
        right = ne - win_stop;
        cov_origin = cov_origin - left[11:0];
        for (int unsigned i = 0; i < left; i++) cov_depth[slot_of(i)] = 0;
        for (int unsigned i = 0; i < right; i++) cov_depth[slot_of(left + old_len + i)] = 0;
        win_start = ns;
        win_stop = ne;
        off = b - ns;
        for (int unsigned i = 0; i < len; i++) begin
            k = slot_of(off + i);
            if (cov_depth[k] != 16'hFFFF) cov_depth[k] = cov_depth[k] + 1;
        end
        return ict_pkg::STAT_OK;
    endfunction

    function automatic ict_pkg::res_t pileup_step(cmd_item_t c);
        ict_pkg::res_t r;
        r = '0;
        case (c.op)
            ict_pkg::OP_ADD: r.status = add_interval(c.contig, c.rbeg, c.rend);
            ict_pkg::OP_QUERY: begin
                if (c.rend > c.rbeg) begin
                    if (!win_valid || c.rbeg < win_start || c.rend > win_stop)
                        r.status = (win_valid && c.contig != win_contig) ?
                                   ict_pkg::STAT_MISMATCH : ict_pkg::STAT_OUTSIDE;
                    else if (c.contig != win_contig)
                        r.status = ict_pkg::STAT_MISMATCH;
                    else
                        range_stats(c.rbeg - win_start, c.rend - c.rbeg, r);
                end
            end
            ict_pkg::OP_CLEAR: begin
                win_valid = 0;
                cov_origin = 0;
                win_start = 0;
                win_stop = 0;
                win_contig = 0;
            end
            default: if (win_valid) range_stats(0, win_stop - win_start, r);
        endcase
        r.window_first = win_start;
        r.window_last = win_stop;
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        mismatch_cnt++;
    endtask

    // driver: new inputs at the falling edge
    always @(negedge aclk) begin
        cmd_item_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && taken_cnt != sent_cnt) begin
            // transaction still waiting for tready
        end else if (cmd_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            c = cmd_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {c.rend, c.rbeg, c.contig};
            s_tuser <= c.op;
            sent_cnt++;
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: sample at the rising edge
    int idle_cycles = 0;
    always @(posedge aclk) begin
        cmd_item_t c;
        ict_pkg::res_t want;
        bit fired;
        fired = 0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                c.contig = s_tdata[15:0];
                c.rbeg = s_tdata[47:16];
                c.rend = s_tdata[79:48];
                c.op = s_tuser;
                pileup_q.push_back(pileup_step(c));
                taken_cnt++;
                fired = 1;
            end
            if (m_tvalid && m_tready) begin
                fired = 1;
                if (pileup_q.size() == 0) begin
                    report("unexpected transaction", m_tuser, 0);
                end else begin
                    want = pileup_q.pop_front();
                    if (m_tuser != want.status) report("status", m_tuser, want.status);
                    if (m_tdata[15:0] != want.depth_min)
                        report("depth_min", m_tdata[15:0], want.depth_min);
                    if (m_tdata[31:16] != want.depth_max)
                        report("depth_max", m_tdata[31:16], want.depth_max);
                    if (m_tdata[59:32] != want.depth_sum)
                        report("depth_sum", m_tdata[59:32], want.depth_sum);
                    if (m_tdata[103:60] != want.depth_sum_squares)
                        report("depth_sum_squares", m_tdata[103:60], want.depth_sum_squares);
                    if (m_tdata[116:104] != want.range_length)
                        report("range_length", m_tdata[116:104], want.range_length);
                    if (m_tdata[148:117] != want.window_first)
                        report("window_first", m_tdata[148:117], want.window_first);
                    if (m_tdata[180:149] != want.window_last)
                        report("window_last", m_tdata[180:149], want.window_last);
                end
            end
            idle_cycles = fired ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [15:0] contig, logic [31:0] b,
                            logic [31:0] e);
        cmd_item_t c;
        c.op = op;
        c.contig = contig;
        c.rbeg = b;
        c.rend = e;
        cmd_q.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || s_tvalid || sent_cnt != taken_cnt || pileup_q.size() > 0)
            @(posedge aclk);
    endtask

    task automatic new_anchor();
        gen_contig = 16'($urandom_range(65535));
        gen_anchor = $urandom_range(32'hFFFF_D000);
    endtask

    // mostly well-formed traffic around one anchor, some clears and noise
    task automatic push_random(int n);
        logic [31:0] b;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                push_cmd(2'($urandom_range(3)), 16'($urandom_range(65535)), $urandom,
                         $urandom);
            end else if (r < 11) begin
                push_cmd(ict_pkg::OP_CLEAR, 16'($urandom_range(65535)), $urandom, $urandom);
                new_anchor();
            end else if (r < 14) begin
                push_cmd(ict_pkg::OP_ADD, gen_contig ^ 16'($urandom_range(1, 65535)),
                         gen_anchor, gen_anchor + 5);
            end else if (r < 55) begin
                b = gen_anchor + $urandom_range(200);
                push_cmd(ict_pkg::OP_ADD, gen_contig, b,
                         b + (($urandom_range(19) == 0) ? $urandom_range(600)
                                                         : $urandom_range(1, 64)));
            end else if (r < 85) begin
                b = gen_anchor + $urandom_range(250);
                push_cmd(ict_pkg::OP_QUERY, gen_contig, b, b + $urandom_range(80));
            end else if (r < 92) begin
                push_cmd(ict_pkg::OP_WHOLE, 16'($urandom_range(65535)), $urandom, $urandom);
            end else begin
                b = gen_anchor - 16 + $urandom_range(300);
                push_cmd(ict_pkg::OP_QUERY, gen_contig, b, b + $urandom_range(1, 40));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed
        push_cmd(ict_pkg::OP_WHOLE, 16'h0000, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_QUERY, 16'h0000, 32'h0, 32'h10);
        push_cmd(ict_pkg::OP_ADD, 16'h1234, 32'h20, 32'h20);
        push_cmd(ict_pkg::OP_ADD, 16'h1234, 32'h0, 32'd4097);
        push_cmd(ict_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_F000, 32'hFFFF_FFFF);
        push_cmd(ict_pkg::OP_ADD, 16'h0001, 32'hFFFF_F000, 32'hFFFF_F010);
        push_cmd(ict_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_F800, 32'hFFFF_F900);
        push_cmd(ict_pkg::OP_WHOLE, 16'h0000, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_QUERY, 16'hFFFF, 32'hFFFF_EFFF, 32'hFFFF_F010);
        push_cmd(ict_pkg::OP_QUERY, 16'h0002, 32'h0, 32'h10);
        push_cmd(ict_pkg::OP_QUERY, 16'h0002, 32'hFFFF_F800, 32'hFFFF_F804);
        push_cmd(ict_pkg::OP_QUERY, 16'hFFFF, 32'hFFFF_F804, 32'hFFFF_F800);
        push_cmd(ict_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_EFFE, 32'hFFFF_F000);
        push_cmd(ict_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_EFFF, 32'hFFFF_F000);
        push_cmd(ict_pkg::OP_QUERY, 16'hFFFF, 32'hFFFF_EFFF, 32'hFFFF_FFFF);
        push_cmd(ict_pkg::OP_CLEAR, 16'h0000, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_WHOLE, 16'h0000, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_ADD, 16'h0000, 32'h0, 32'h1);
        push_cmd(ict_pkg::OP_ADD, 16'h0000, 32'h5, 32'hA);
        push_cmd(ict_pkg::OP_QUERY, 16'h0000, 32'h0, 32'hA);
        push_cmd(ict_pkg::OP_ADD, 16'h0000, 32'h0, 32'd4096);
        push_cmd(ict_pkg::OP_WHOLE, 16'h0000, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_CLEAR, 16'h0000, 32'h0, 32'h0);
        wait_drained();

        // repeated increments on a two-position interval
        push_cmd(ict_pkg::OP_ADD, 16'h0007, 32'd100, 32'd101);
        for (int i = 0; i < 20; i++) push_cmd(ict_pkg::OP_ADD, 16'h0007, 32'd100, 32'd102);
        push_cmd(ict_pkg::OP_WHOLE, 16'h0007, 32'h0, 32'h0);
        push_cmd(ict_pkg::OP_CLEAR, 16'h0000, 32'h0, 32'h0);
        wait_drained();

        new_anchor();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                default: begin src_idle_pct = 25; snk_stall_pct = 25; end
            endcase
            push_random(427);
            wait_drained();
        end

        repeat (50) @(posedge aclk);
        if (mismatch_cnt == 0 && pileup_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
